FILE: rtl/motion_capture_text_lexer_assert.svh
// assertion macros shared by the lexer rtl
`ifndef MOTION_CAPTURE_TEXT_LEXER_ASSERT_SVH
`define MOTION_CAPTURE_TEXT_LEXER_ASSERT_SVH

// property checked on every clock outside reset
`define MCTL_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// consequent checked in the clock after the antecedent
`define MCTL_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mctl_pkg.sv
// types, constants and keyword tables of the motion capture text lexer
`default_nettype none

package mctl_pkg;

  localparam int TOKEN_LENGTH_MAX = 255;
  localparam int CNT_W = $clog2(TOKEN_LENGTH_MAX + 1);
  localparam int KW_COUNT = 11;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // token kind codes
  localparam logic [4:0] TK_STRING = 5'd11;
  localparam logic [4:0] TK_NUMBER = 5'd12;
  localparam logic [4:0] TK_LBRACE = 5'd13;
  localparam logic [4:0] TK_RBRACE = 5'd14;
  localparam logic [4:0] TK_COLON  = 5'd15;
  localparam logic [4:0] TK_ERROR  = 5'd16;
  localparam logic [4:0] TK_EOF    = 5'd17;

  // characters with a meaning of their own
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_INT,
    MODE_FRAC
  } mode_t;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [KW_COUNT-1:0] kw_mask_t;
  typedef logic [FIFO_PTR_W-1:0] fifo_ptr_t;
  typedef logic [FIFO_CNT_W-1:0] fifo_cnt_t;

  // queue fill levels: completely full, and the most that still leaves two free slots
  localparam fifo_cnt_t FIFO_FULL       = fifo_cnt_t'(FIFO_DEPTH);
  localparam fifo_cnt_t FIFO_ROOM_LIMIT = fifo_cnt_t'(FIFO_DEPTH - 2);

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] length;
    logic       last;
  } token_t;

  // up to two tokens produced by one input word
  typedef struct packed {
    logic [1:0] n;
    token_t     t0;
    token_t     t1;
  } step_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [3:0] kw_len(logic [3:0] k);
    logic [3:0] len;
    unique case (k)
      4'd0:    len = 4'd9;
      4'd1:    len = 4'd4;
      4'd2:    len = 4'd6;
      4'd3:    len = 4'd8;
      4'd4:    len = 4'd5;
      4'd5:    len = 4'd3;
      4'd6:    len = 4'd4;
      4'd7:    len = 4'd6;
      4'd8:    len = 4'd6;
      4'd9:    len = 4'd5;
      4'd10:   len = 4'd4;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  // character at position pos of keyword k, zero past its end
  function automatic logic [7:0] kw_char(logic [3:0] k, logic [3:0] pos);
    logic [71:0] txt;
    logic [3:0]  len;
    logic [6:0]  sh;
    logic [71:0] moved;
    unique case (k)
      4'd0:    txt = 72'("HIERARCHY");
      4'd1:    txt = 72'("ROOT");
      4'd2:    txt = 72'("OFFSET");
      4'd3:    txt = 72'("CHANNELS");
      4'd4:    txt = 72'("JOINT");
      4'd5:    txt = 72'("End");
      4'd6:    txt = 72'("Site");
      4'd7:    txt = 72'("MOTION");
      4'd8:    txt = 72'("Frames");
      4'd9:    txt = 72'("Frame");
      4'd10:   txt = 72'("Time");
      default: txt = '0;
    endcase
    len = kw_len(k);
    sh = {4'(len - 4'd1 - pos), 3'b000};
    moved = txt >> sh;
    return (pos < len) ? moved[7:0] : 8'h00;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/motion_capture_text_lexer.sv
// top level of the motion capture text lexer
//
// input channel: item_valid / item_ready carry one word per ready cycle, kind
//   (0 text byte, 1 end of file) and char_byte
// output channel: token_valid / token_ready carry one token word, with
//   token_kind, token_length and last_of_run (set on the final token that
//   one input word gives)
// an accepted word sits in the input register until the queue has room; the
//   scanner then classifies it and pushes zero, one or two tokens into a
//   four-entry queue, where its tokens are registered before they leave
// throughput: one input word per cycle while the queue has room; a word that
//   gives two tokens sends them in turn through the single output port
// the scanner advances only when the queue has two free slots, so item_ready
//   drops when the receiver stalls and the queue fills
// reset (rst, synchronous): queue empty, input register empty, scanner idle
//   between tokens with no open word or number
`default_nettype none

module motion_capture_text_lexer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire logic       kind,
  input  wire logic [7:0] char_byte,
  output logic            token_valid,
  input  wire logic       token_ready,
  output logic [4:0]      token_kind,
  output logic [7:0]      token_length,
  output logic            last_of_run
);

  // input register
  logic       in_full;
  logic       in_eof;
  logic [7:0] in_byte;

  logic             advance;
  logic             room;
  mctl_pkg::step_t  step;
  mctl_pkg::step_t  push;
  mctl_pkg::token_t head;

  // the held word is consumed once the queue can take two tokens
  assign advance    = in_full && room;
  assign item_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_ready) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_eof  <= kind;
      in_byte <= char_byte;
    end
  end

  mctl_scanner u_scanner (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .eof     (in_eof),
    .c       (in_byte),
    .step    (step)
  );

  // only a consumed word pushes tokens
  always_comb begin
    push = step;
    if (!advance) begin
      push.n = 2'd0;
    end
  end

  mctl_token_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (token_valid),
    .out_ready (token_ready),
    .head      (head)
  );

  assign token_kind   = head.kind;
  assign token_length = head.length;
  assign last_of_run  = head.last;

endmodule

`default_nettype wire

FILE: rtl/mctl_scanner.sv
// scan state and per-byte token logic
`default_nettype none

module mctl_scanner (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic            eof,
  input  wire logic [7:0]      c,
  output mctl_pkg::step_t      step
);

  `include "motion_capture_text_lexer_assert.svh"

  mctl_pkg::mode_t    mode, mode_next;
  mctl_pkg::kw_mask_t mask, mask_next;
  mctl_pkg::cnt_t     cnt, cnt_next;

  mctl_pkg::cnt_t     cnt_up;
  mctl_pkg::kw_mask_t upd_mask;
  mctl_pkg::kw_mask_t start_mask;
  mctl_pkg::token_t   fin_tok;
  logic [4:0]         fin_kind;

  mctl_pkg::mode_t    st_mode;
  mctl_pkg::kw_mask_t st_mask;
  mctl_pkg::cnt_t     st_cnt;
  logic               st_emit;
  logic [4:0]         st_kind;
  logic               continuing;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= mctl_pkg::MODE_IDLE;
      mask <= '0;
      cnt  <= '0;
    end else if (advance) begin
      mode <= mode_next;
      mask <= mask_next;
      cnt  <= cnt_next;
    end
  end

  assign cnt_up = (cnt < mctl_pkg::CNT_W'(mctl_pkg::TOKEN_LENGTH_MAX)) ?
                  cnt + mctl_pkg::CNT_W'(1) : cnt;

  // keyword prefix match, next character at position cnt
  always_comb begin
    for (int k = 0; k < mctl_pkg::KW_COUNT; k++) begin
      upd_mask[k] = mask[k]
                    && (cnt < mctl_pkg::CNT_W'(mctl_pkg::kw_len(4'(k))))
                    && (mctl_pkg::kw_char(4'(k), cnt[3:0]) == c);
      start_mask[k] = (mctl_pkg::kw_char(4'(k), 4'd0) == c);
    end
  end

  // kind of the word or number being closed
  always_comb begin
    fin_kind = mctl_pkg::TK_STRING;
    for (int k = 0; k < mctl_pkg::KW_COUNT; k++) begin
      if (mask[k] && cnt == mctl_pkg::CNT_W'(mctl_pkg::kw_len(4'(k)))) begin
        fin_kind = 5'(k);
      end
    end
    fin_tok.kind   = (mode == mctl_pkg::MODE_WORD) ? fin_kind : mctl_pkg::TK_NUMBER;
    fin_tok.length = 8'(cnt);
    fin_tok.last   = 1'b0;
  end

  // what the byte does when it opens a token
  always_comb begin
    st_mode = mctl_pkg::MODE_IDLE;
    st_mask = '0;
    st_cnt  = '0;
    st_emit = 1'b0;
    st_kind = mctl_pkg::TK_ERROR;
    priority if (mctl_pkg::is_space(c)) begin
      st_emit = 1'b0;
    end else if (mctl_pkg::is_alpha(c)) begin
      st_mode = mctl_pkg::MODE_WORD;
      st_mask = start_mask;
      st_cnt  = mctl_pkg::CNT_W'(1);
    end else if (mctl_pkg::is_digit(c) || c == mctl_pkg::CH_MINUS) begin
      st_mode = mctl_pkg::MODE_INT;
      st_cnt  = mctl_pkg::CNT_W'(1);
    end else if (c == mctl_pkg::CH_DOT) begin
      st_mode = mctl_pkg::MODE_FRAC;
      st_cnt  = mctl_pkg::CNT_W'(1);
    end else if (c == mctl_pkg::CH_LBRACE) begin
      st_emit = 1'b1;
      st_kind = mctl_pkg::TK_LBRACE;
    end else if (c == mctl_pkg::CH_RBRACE) begin
      st_emit = 1'b1;
      st_kind = mctl_pkg::TK_RBRACE;
    end else if (c == mctl_pkg::CH_COLON) begin
      st_emit = 1'b1;
      st_kind = mctl_pkg::TK_COLON;
    end else begin
      st_emit = 1'b1;
      st_kind = mctl_pkg::TK_ERROR;
    end
  end

  always_comb begin
    unique case (mode)
      mctl_pkg::MODE_WORD: continuing = mctl_pkg::is_alpha(c) || mctl_pkg::is_digit(c)
                                        || c == mctl_pkg::CH_UNDER
                                        || c == mctl_pkg::CH_MINUS;
      mctl_pkg::MODE_INT:  continuing = mctl_pkg::is_digit(c) || c == mctl_pkg::CH_DOT;
      mctl_pkg::MODE_FRAC: continuing = mctl_pkg::is_digit(c);
      default:             continuing = 1'b0;
    endcase
  end

  // next state and tokens
  always_comb begin
    mode_next = mode;
    mask_next = mask;
    cnt_next  = cnt;
    step      = '0;
    if (eof) begin
      mode_next = mctl_pkg::MODE_IDLE;
      mask_next = '0;
      cnt_next  = '0;
      if (mode != mctl_pkg::MODE_IDLE) begin
        step.n  = 2'd2;
        step.t0 = fin_tok;
        step.t1 = '{kind: mctl_pkg::TK_EOF, length: 8'd0, last: 1'b1};
      end else begin
        step.n  = 2'd1;
        step.t0 = '{kind: mctl_pkg::TK_EOF, length: 8'd0, last: 1'b1};
      end
    end else if (continuing) begin
      cnt_next = cnt_up;
      if (mode == mctl_pkg::MODE_WORD) begin
        mask_next = upd_mask;
      end
      if (mode == mctl_pkg::MODE_INT && c == mctl_pkg::CH_DOT) begin
        mode_next = mctl_pkg::MODE_FRAC;
      end
    end else begin
      mode_next = st_mode;
      mask_next = st_mask;
      cnt_next  = st_cnt;
      if (mode != mctl_pkg::MODE_IDLE) begin
        step.t0 = fin_tok;
        if (st_emit) begin
          step.n  = 2'd2;
          step.t1 = '{kind: st_kind, length: 8'd1, last: 1'b1};
        end else begin
          step.n       = 2'd1;
          step.t0.last = 1'b1;
        end
      end else if (st_emit) begin
        step.n  = 2'd1;
        step.t0 = '{kind: st_kind, length: 8'd1, last: 1'b1};
      end
    end
  end

  `MCTL_CHECK(a_mask_only_in_word, (mode != mctl_pkg::MODE_WORD) |-> (mask == '0), "mask set outside word")
  `MCTL_CHECK(a_last_on_second, (step.n == 2'd2) |-> (step.t1.last && !step.t0.last), "last flag misplaced")
  `MCTL_CHECK_NEXT(a_eof_to_idle, advance && eof, mode == mctl_pkg::MODE_IDLE && cnt == '0, "eof left a token open")

endmodule

`default_nettype wire

FILE: rtl/mctl_token_fifo.sv
// small token queue between the scanner and the output port
`default_nettype none

module mctl_token_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mctl_pkg::step_t  push,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mctl_pkg::token_t      head
);

  `include "motion_capture_text_lexer_assert.svh"

  mctl_pkg::token_t    mem [mctl_pkg::FIFO_DEPTH];
  mctl_pkg::fifo_ptr_t wr_ptr;
  mctl_pkg::fifo_ptr_t rd_ptr;
  mctl_pkg::fifo_cnt_t count;
  mctl_pkg::fifo_cnt_t count_next;
  logic                pop;

  assign out_valid  = (count != '0);
  assign pop        = out_valid && out_ready;
  assign head       = mem[rd_ptr];
  assign count_next = count + mctl_pkg::fifo_cnt_t'(push.n) - mctl_pkg::fifo_cnt_t'(pop);
  // two free slots after this cycle's pop
  assign room       = (count - mctl_pkg::fifo_cnt_t'(pop)) <= mctl_pkg::FIFO_ROOM_LIMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + mctl_pkg::fifo_ptr_t'(push.n);
      rd_ptr <= rd_ptr + mctl_pkg::fifo_ptr_t'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.t0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + mctl_pkg::fifo_ptr_t'(1)] <= push.t1;
    end
  end

  `MCTL_CHECK(a_no_overflow, count <= mctl_pkg::FIFO_FULL, "queue count over depth")
  `MCTL_CHECK(a_push_needs_room, (push.n != 2'd0) |-> room, "push without room")
  `MCTL_CHECK_NEXT(a_count_tracks, 1'b1, count == $past(count_next), "queue count drift")

endmodule

`default_nettype wire
